// ===== hw/rtl/pesr_pkg.sv =====
`timescale 1ns / 1ps

package pesr_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int DIST_BITS_DEF  = 40;

    localparam int SPACING_W = 20;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 20'd1000;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index = paddr[APB_ADDR_W-1:2]
    localparam logic [APB_ADDR_W-3:0] REG_IDX_SPACING = 1'b0;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic {
        KIND_FIRST = 1'b0,
        KIND_STEP  = 1'b1
    } item_kind_t;

endpackage

// ===== hw/rtl/pesr_front.sv =====
`timescale 1ns / 1ps

module pesr_front
    import pesr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 * COORD_BITS + 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] pos_x_mm,
    input  logic signed [COORD_BITS-1:0] pos_y_mm,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [ENTRY_W-1:0]           q_data
);

    localparam int MAG_W = COORD_BITS + 1;

    logic                  seen_any_reg;
    logic [COORD_BITS-1:0] prev_x_reg;
    logic [COORD_BITS-1:0] prev_y_reg;

    logic             accept;
    logic             dup;
    logic [MAG_W-1:0] dx;
    logic [MAG_W-1:0] dy;
    item_kind_t       kind;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign dup      = (pos_x_mm == prev_x_reg) && (pos_y_mm == prev_y_reg);

    // signed differences, one bit wider than the coordinates
    assign dx = {pos_x_mm[COORD_BITS-1], pos_x_mm} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign dy = {pos_y_mm[COORD_BITS-1], pos_y_mm} - {prev_y_reg[COORD_BITS-1], prev_y_reg};

    assign kind   = seen_any_reg ? KIND_STEP : KIND_FIRST;
    assign q_push = accept && (!seen_any_reg || !dup);
    assign q_data = {kind, pos_x_mm, pos_y_mm, dx, dy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_any_reg <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end
        else if (q_push)
        begin
            seen_any_reg <= 1'b1;
            prev_x_reg   <= pos_x_mm;
            prev_y_reg   <= pos_y_mm;
        end
    end

endmodule

// ===== hw/rtl/pesr_queue.sv =====
`timescale 1ns / 1ps

module pesr_queue
    import pesr_pkg::*;
#(
    parameter int WIDTH = 4 * COORD_BITS_DEF + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(FIFO_DEPTH)) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue underflow");

endmodule

// ===== hw/rtl/pesr_back.sv =====
`timescale 1ns / 1ps

module pesr_back
    import pesr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF,
    parameter int ENTRY_W    = 4 * COORD_BITS + 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [SPACING_W-1:0]         spacing,
    input  logic                         q_valid,
    input  logic [ENTRY_W-1:0]           q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] out_x_mm,
    output logic signed [COORD_BITS-1:0] out_y_mm,
    output logic [DIST_BITS-1:0]         path_dist_mm
);

    localparam int MAG_W  = COORD_BITS + 1;          // |dx|, |dy|
    localparam int HALF_W = (MAG_W + 1) / 2;         // multiplier slice
    localparam int ROOT_W = MAG_W + 1;               // sqrt(dx^2 + dy^2)
    localparam int ACC_W  = 2 * ROOT_W;              // radicand
    localparam int REM_W  = ROOT_W + 2;
    localparam int PP_W   = MAG_W + HALF_W;
    localparam int SUM_W  = ((ROOT_W > DIST_BITS) ? ROOT_W : DIST_BITS) + 1;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_ABS,
        S_MUL,
        S_DRAIN,
        S_SQRT,
        S_ADD,
        S_CHECK
    } state_t;

    state_t                state_reg;
    logic [1:0]            mul_cnt_reg;
    logic [CNT_W-1:0]      sqrt_cnt_reg;
    logic                  pp_valid_reg;
    logic                  pp_hi_reg;
    logic [DIST_BITS-1:0]  run_reg;
    logic [DIST_BITS-1:0]  anchor_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [DIST_BITS-1:0]  out_dist_reg;

    // datapath
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [MAG_W-1:0]      dx_reg;
    logic [MAG_W-1:0]      dy_reg;
    logic [MAG_W-1:0]      mag_x_reg;
    logic [MAG_W-1:0]      mag_y_reg;
    logic [PP_W-1:0]       pp_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic                  slot_free;
    logic [MAG_W-1:0]      mul_a;
    logic [2*HALF_W-1:0]   mul_ext;
    logic [HALF_W-1:0]     mul_b;
    logic [ACC_W-1:0]      pp_ext;
    logic [REM_W-1:0]      rem_shift;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      rem_next;
    logic [ROOT_W-1:0]     root_next;
    logic [SUM_W-1:0]      sum;
    logic [DIST_BITS-1:0]  run_next;
    logic [DIST_BITS-1:0]  gap;
    logic                  emit;
    logic                  out_load;

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign slot_free    = !out_valid_reg || !out_stall;
    assign out_load     = slot_free &&
                          ((state_reg == S_FIRST) || ((state_reg == S_CHECK) && emit));
    assign out_valid    = out_valid_reg;
    assign out_x_mm     = out_x_reg;
    assign out_y_mm     = out_y_reg;
    assign path_dist_mm = out_dist_reg;

    // four partial products: ax*ax_lo, ax*ax_hi, ay*ay_lo, ay*ay_hi
    always_comb
    begin
        mul_a   = mul_cnt_reg[1] ? mag_y_reg : mag_x_reg;
        mul_ext = (2 * HALF_W)'(mul_a);
        mul_b   = mul_cnt_reg[0] ? mul_ext[2*HALF_W-1:HALF_W] : mul_ext[HALF_W-1:0];
        pp_ext  = pp_hi_reg ? (ACC_W'(pp_reg) << HALF_W) : ACC_W'(pp_reg);
    end

    // one root bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], acc_reg[ACC_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        sum      = SUM_W'(run_reg) + SUM_W'(root_reg);
        run_next = (sum >= SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
        gap      = run_reg - anchor_reg;
        emit     = (gap >= DIST_BITS'(spacing));
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            {x_reg, y_reg, dx_reg, dy_reg} <= q_data[ENTRY_W-2:0];
        end
        if (state_reg == S_ABS)
        begin
            mag_x_reg <= dx_reg[MAG_W-1] ? (~dx_reg + 1'b1) : dx_reg;
            mag_y_reg <= dy_reg[MAG_W-1] ? (~dy_reg + 1'b1) : dy_reg;
            acc_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (state_reg == S_SQRT)
        begin
            acc_reg  <= acc_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        else if (pp_valid_reg)
        begin
            acc_reg <= acc_reg + pp_ext;
        end
        if (state_reg == S_MUL)
        begin
            pp_reg <= PP_W'(mul_a) * PP_W'(mul_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_cnt_reg   <= '0;
            sqrt_cnt_reg  <= '0;
            pp_valid_reg  <= 1'b0;
            pp_hi_reg     <= 1'b0;
            run_reg       <= '0;
            anchor_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_dist_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            pp_valid_reg  <= (state_reg == S_MUL);
            pp_hi_reg     <= mul_cnt_reg[0];

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= (q_data[ENTRY_W-1] == KIND_FIRST) ? S_FIRST : S_ABS;
                    end
                end
                S_FIRST:
                begin
                    if (slot_free)
                    begin
                        run_reg       <= '0;
                        anchor_reg    <= '0;
                        out_x_reg     <= x_reg;
                        out_y_reg     <= y_reg;
                        out_dist_reg  <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_ABS:
                begin
                    mul_cnt_reg <= '0;
                    state_reg   <= S_MUL;
                end
                S_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == 2'd3)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    sqrt_cnt_reg <= CNT_W'(ROOT_W - 1);
                    state_reg    <= S_SQRT;
                end
                S_SQRT:
                begin
                    sqrt_cnt_reg <= sqrt_cnt_reg - 1'b1;
                    if (sqrt_cnt_reg == '0)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    run_reg   <= run_next;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!emit)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        anchor_reg    <= run_reg;
                        out_x_reg     <= x_reg;
                        out_y_reg     <= y_reg;
                        out_dist_reg  <= run_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_anchor_behind_run: assert property (@(posedge clk) disable iff (!rst_n)
        anchor_reg <= run_reg)
        else $error("anchor length ahead of running length");

    a_run_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |=> (run_reg >= $past(run_reg)))
        else $error("running length decreased on a step");

endmodule

// ===== hw/rtl/path_equal_spacing_resampler.sv =====
`timescale 1ns / 1ps

// Resamples a stream of planar route points (signed mm) to points spaced by at
// least spacing_mm of path length. Repeated points are dropped at the input at
// one per cycle while the queue is not full and cost nothing else; the first
// point goes out with distance zero. Each other point passes through four
// partial products in the back end, then a bit-serial square root that
// produces one root bit per cycle.
// A two-entry queue sits between the input and the arithmetic, and the
// result register lets the next point start while a result waits.
// spacing_mm sits at byte address 0, reset 1000.
module path_equal_spacing_resampler
    import pesr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] pos_x_mm,
    input  logic signed [COORD_BITS-1:0] pos_y_mm,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] out_x_mm,
    output logic signed [COORD_BITS-1:0] out_y_mm,
    output logic [DIST_BITS-1:0]         path_dist_mm
);

    localparam int ENTRY_W = 4 * COORD_BITS + 3;

    logic [SPACING_W-1:0] spacing_reg;
    logic                 q_push;
    logic [ENTRY_W-1:0]   q_push_data;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;
    logic [ENTRY_W-1:0]   q_pop_data;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_IDX_SPACING) ?
                    APB_DATA_W'(spacing_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[APB_ADDR_W-1:2] == REG_IDX_SPACING))
        begin
            spacing_reg <= pwdata[SPACING_W-1:0];
        end
    end

    pesr_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pos_x_mm (pos_x_mm),
        .pos_y_mm (pos_y_mm),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    pesr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    pesr_back #(
        .COORD_BITS (COORD_BITS),
        .DIST_BITS  (DIST_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .spacing      (spacing_reg),
        .q_valid      (q_not_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x_mm     (out_x_mm),
        .out_y_mm     (out_y_mm),
        .path_dist_mm (path_dist_mm)
    );

endmodule

// ===== dv/resample_checker.sv =====
`timescale 1ns / 1ps

module resample_checker
    import pesr_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [APB_ADDR_W-1:0]            paddr,
    input  logic [APB_DATA_W-1:0]            pwdata,
    input  logic [APB_DATA_W-1:0]            prdata,

    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic signed [COORD_BITS_DEF-1:0] pos_x_mm,
    input  logic signed [COORD_BITS_DEF-1:0] pos_y_mm,

    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic signed [COORD_BITS_DEF-1:0] out_x_mm,
    input  logic signed [COORD_BITS_DEF-1:0] out_y_mm,
    input  logic [DIST_BITS_DEF-1:0]         path_dist_mm,

    output int                               mismatches,
    output int                               backlog
);

    localparam int CW = COORD_BITS_DEF;
    localparam int DW = DIST_BITS_DEF;
    localparam logic [DW-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [DW-1:0]        dist_mm;
    } route_point_t;

    route_point_t         expected_points[$];
    route_point_t         oldest;
    logic                 have_first;
    logic signed [CW-1:0] last_x;
    logic signed [CW-1:0] last_y;
    logic [DW-1:0]        path_len;
    logic [DW-1:0]        anchor_len;
    logic [SPACING_W-1:0] spacing;
    int                   reported;

    // floor of the exact Euclidean distance between two points
    function automatic logic [DW-1:0] segment_length(input logic signed [CW-1:0] x0,
                                                     input logic signed [CW-1:0] y0,
                                                     input logic signed [CW-1:0] x1,
                                                     input logic signed [CW-1:0] y1);
        longint             dx;
        longint             dy;
        logic [2*CW+3:0]    ax;
        logic [2*CW+3:0]    ay;
        logic [2*CW+3:0]    sq;
        logic [2*CW+3:0]    root;
        logic [2*CW+3:0]    trial;
        dx = longint'(x1) - longint'(x0);
        dy = longint'(y1) - longint'(y0);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        ax = (2*CW+4)'(dx);
        ay = (2*CW+4)'(dy);
        sq = ax * ax + ay * ay;
        root = '0;
        for (int b = CW + 1; b >= 0; b--)
        begin
            trial = root | ((2*CW+4)'(1) << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root[DW-1:0];
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (reported < 10)
        begin
            reported++;
            $display("[%0t] MISMATCH %s", $time, msg);
        end
    endtask

    // update path length and queue a point when it is due
    task automatic advance_route(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        route_point_t  pt;
        logic [DW-1:0] seg;
        pt.x = x;
        pt.y = y;
        if (!have_first)
        begin
            have_first = 1'b1;
            last_x     = x;
            last_y     = y;
            path_len   = '0;
            anchor_len = '0;
            pt.dist_mm = '0;
            expected_points = {expected_points, pt};
            return;
        end
        if (x == last_x && y == last_y)
            return;
        seg = segment_length(last_x, last_y, x, y);
        if (seg >= DIST_MAX - path_len)
            path_len = DIST_MAX;
        else
            path_len = path_len + seg;
        last_x = x;
        last_y = y;
        if (path_len - anchor_len >= DW'(spacing))
        begin
            anchor_len = path_len;
            pt.dist_mm = path_len;
            expected_points = {expected_points, pt};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first = 1'b0;
            last_x     = '0;
            last_y     = '0;
            path_len   = '0;
            anchor_len = '0;
            spacing    = SPACING_RESET;
            expected_points.delete();
            mismatches = 0;
            reported   = 0;
            backlog    = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_IDX_SPACING)
            begin
                if (pwrite)
                    spacing = pwdata[SPACING_W-1:0];
                else if (prdata !== APB_DATA_W'(spacing))
                    note_failure($sformatf("spacing readback: expected %0d, got %0d",
                                           spacing, prdata));
            end
            if (in_valid && !in_stall)
                advance_route(pos_x_mm, pos_y_mm);
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                    note_failure($sformatf("unexpected transaction x=%0d y=%0d dist=%0d",
                                           out_x_mm, out_y_mm, path_dist_mm));
                else
                begin
                    oldest = expected_points.pop_front();
                    if (out_x_mm !== oldest.x || out_y_mm !== oldest.y
                        || path_dist_mm !== oldest.dist_mm)
                        note_failure($sformatf(
                            "expected x=%0d y=%0d dist=%0d, got x=%0d y=%0d dist=%0d",
                            oldest.x, oldest.y, oldest.dist_mm,
                            out_x_mm, out_y_mm, path_dist_mm));
                end
            end
            backlog = expected_points.size();
        end
    end

endmodule

// ===== dv/tb_path_equal_spacing_resampler.sv =====
`timescale 1ns / 1ps

module tb_path_equal_spacing_resampler;
    import pesr_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int DW = DIST_BITS_DEF;
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [APB_ADDR_W-1:0] SPACING_ADDR = {REG_IDX_SPACING, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [CW-1:0]  pos_x_mm;
    logic signed [CW-1:0]  pos_y_mm;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [CW-1:0]  out_x_mm;
    logic signed [CW-1:0]  out_y_mm;
    logic [DW-1:0]         path_dist_mm;

    int                    mismatches;
    int                    backlog;
    logic                  calm;
    logic signed [CW-1:0]  cur_x;
    logic signed [CW-1:0]  cur_y;

    path_equal_spacing_resampler #(
        .COORD_BITS (CW),
        .DIST_BITS  (DW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x_mm     (pos_x_mm),
        .pos_y_mm     (pos_y_mm),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x_mm     (out_x_mm),
        .out_y_mm     (out_y_mm),
        .path_dist_mm (path_dist_mm)
    );

    resample_checker route_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x_mm     (pos_x_mm),
        .pos_y_mm     (pos_y_mm),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x_mm     (out_x_mm),
        .out_y_mm     (out_y_mm),
        .path_dist_mm (path_dist_mm),
        .mismatches   (mismatches),
        .backlog      (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("tb_path_equal_spacing_resampler: errors");
        $finish;
    end

    // receiver: random hold-off per transaction
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 11);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pos_x_mm <= x;
        pos_y_mm <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cur_x = x;
        cur_y = y;
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= SPACING_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drain all expected transactions, then cover points still in the pipe
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);
    endtask

    task automatic set_spacing(input logic [SPACING_W-1:0] sp);
        settle();
        apb_access(1'b1, APB_DATA_W'(sp));
        apb_access(1'b0, '0);
    endtask

    function automatic logic signed [CW-1:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return C_MIN;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return C_MAX;
        endcase
    endfunction

    task automatic wander(input int count, input int sp);
        int r;
        int reach;
        int dx;
        int dy;
        reach = 2 * sp + 3;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            r = $urandom_range(0, 99);
            if (r < 10)
                send_point(cur_x, cur_y);
            else if (r < 70)
            begin
                dx = $urandom_range(0, reach);
                dy = $urandom_range(0, reach);
                if ($urandom_range(0, 1))
                    dx = -dx;
                if ($urandom_range(0, 1))
                    dy = -dy;
                send_point(cur_x + dx, cur_y + dy);
            end
            else if (r < 85)
                send_point($urandom, $urandom);
            else
                send_point(corner_value(), corner_value());
        end
    endtask

    initial
    begin
        int sp;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        pos_x_mm = '0;
        pos_y_mm = '0;
        calm     = 1'b0;
        cur_x    = '0;
        cur_y    = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of spacing, then directed points
        apb_access(1'b0, '0);
        send_point(0, 0);
        send_point(0, 0);
        send_point(3000, 4000);
        send_point(3000, 4000);
        send_point(3999, 4000);
        send_point(4000, 4000);
        send_point(4001, 4001);
        send_point(C_MAX, C_MAX);
        send_point(C_MIN, C_MIN);
        send_point(C_MAX, C_MIN);
        send_point(C_MIN, C_MAX);
        send_point(-1, -1);
        send_point(0, C_MAX);
        send_point(C_MIN, 0);

        // zero spacing: every new point goes out, repeats still dropped
        set_spacing('0);
        send_point(C_MIN, 0);
        send_point(C_MIN + 1, 0);
        send_point(C_MIN + 1, 1);

        set_spacing(1);
        send_point(C_MIN + 1, 1);
        send_point(C_MIN + 2, 1);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       sp = 1000000;
                1:       sp = 1;
                2:       sp = 1000;
                3:       sp = 0;
                default: sp = $urandom_range(1, 1000000);
            endcase
            set_spacing(SPACING_W'(sp));
            wander(80, sp);
        end

        // drive the path length into saturation; nothing goes out after that
        set_spacing(SPACING_W'(1000000));
        calm = 1'b0;
        for (int i = 0; i < 200; i++)
        begin
            if (i % 2)
                send_point(C_MAX, C_MAX);
            else
                send_point(C_MIN, C_MIN);
        end
        send_point(cur_x, cur_y);
        for (int i = 0; i < 8; i++)
            send_point($urandom, $urandom);

        settle();
        if (mismatches == 0 && backlog == 0)
            $display("tb_path_equal_spacing_resampler: clean");
        else
            $display("tb_path_equal_spacing_resampler: errors");
        $finish;
    end

endmodule

// ===== path_equal_spacing_resampler.f =====
hw/rtl/pesr_pkg.sv
hw/rtl/pesr_front.sv
hw/rtl/pesr_queue.sv
hw/rtl/pesr_back.sv
hw/rtl/path_equal_spacing_resampler.sv
dv/resample_checker.sv
dv/tb_path_equal_spacing_resampler.sv
